// ===== hw/rtl/sdiv_pkg.sv =====
// Shared types, widths and constants for the signed integer divider.
package sdiv_pkg;

  // Operand and quotient width.
  localparam int DATA_WIDTH = 32;
  // Width of the step counter inside the controller.
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // Most negative and most positive two's complement values.
  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] NEG_ONE = {DATA_WIDTH{1'b1}};

  // Input item.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } sdiv_in_t;

  // Result item.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         overflow;
    logic                         div_by_zero;
  } sdiv_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } sdiv_state_t;

  // Control signals from the controller to the datapath.
  typedef struct packed {
    logic busy;
    logic load;
    logic step;
    logic finish;
  } sdiv_ctl_t;

endpackage

// ===== hw/rtl/sdiv_cell.sv =====
// One bit slice of the restoring divider: remainder, divisor and quotient bits.
module sdiv_cell
  import sdiv_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  logic step,
  input  logic load_den,
  input  logic load_quo,
  input  logic rem_in,
  input  logic quo_in,
  input  logic borrow_in,
  input  logic ge,
  output logic rem_o,
  output logic quo_o,
  output logic borrow_o
);

  logic rem_r, rem_nxt;
  logic den_r;
  logic quo_r, quo_nxt;
  logic diff;

  // Trial subtraction bit: shifted remainder bit minus divisor bit.
  assign diff     = rem_in ^ den_r ^ borrow_in;
  assign borrow_o = (~rem_in & den_r) | (~(rem_in ^ den_r) & borrow_in);

  // Keep the difference when the whole trial did not borrow.
  always_comb begin
    rem_nxt = ge ? diff : rem_in;
    quo_nxt = quo_in;
  end

  // Slice registers; loaded with a new item, shifted once per step.
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= 1'b0;
      den_r <= load_den;
      quo_r <= load_quo;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

// ===== hw/rtl/sdiv_ctrl.sv =====
// Sequencer for the divider: load, one step per quotient bit, then finish.
module sdiv_ctrl
  import sdiv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output sdiv_ctl_t ctl
);

  sdiv_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctl.busy   = 1'b1;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/signed_int32_divider.sv =====
// Top level of the signed divider: operand prep, chain of bit slices, result.
//
//   Channel   Ports                         Handshake
//   input     start, busy, in_data          taken when start is high and busy low
//   result    out_valid, out_data           shown for one cycle, no back-pressure
//
// After acceptance an item takes one step of the slice chain per quotient bit,
// then the finishing state applies the sign and the special cases, and the
// result passes through the output register to its strobe. The ripple borrow
// across the slice chain sets the clock period. busy drops in the cycle the
// result is shown, so the next item can be accepted then. Reset is synchronous
// and clears the controller and the result strobe.
module signed_int32_divider
  import sdiv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sdiv_in_t  in_data,
  output logic      out_valid,
  output sdiv_out_t out_data
);

  sdiv_ctl_t ctl;

  logic [DATA_WIDTH-1:0] a_u, b_u, mag_a, mag_b;
  logic [DATA_WIDTH-1:0] rem_w, quo_w, borrow_w;
  logic                  ge;
  logic                  neg_r, dz_r, ovf_r;
  logic                  out_valid_r;
  sdiv_out_t             out_r, out_nxt;

  // Sequencer.
  sdiv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ctl   (ctl)
  );

  assign busy = ctl.busy;

  // Operand magnitudes.
  assign a_u   = in_data.dividend;
  assign b_u   = in_data.divisor;
  assign mag_a = a_u[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - a_u) : a_u;
  assign mag_b = b_u[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - b_u) : b_u;

  // Sign and special-case flags captured with the item.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      dz_r  <= (b_u == '0);
      ovf_r <= (a_u == MIN_VAL) && (b_u == NEG_ONE);
    end
  end

  // The trial subtraction succeeds when the top slice does not borrow.
  assign ge = ~borrow_w[DATA_WIDTH-1];

  // Chain of bit slices; remainder and quotient shift one slice per step.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    logic rem_in, quo_in, borrow_in;
    if (i == 0) begin : g_first
      assign rem_in    = quo_w[DATA_WIDTH-1];
      assign quo_in    = ge;
      assign borrow_in = 1'b0;
    end else begin : g_rest
      assign rem_in    = rem_w[i-1];
      assign quo_in    = quo_w[i-1];
      assign borrow_in = borrow_w[i-1];
    end

    sdiv_cell u_cell (
      .clk       (clk),
      .load      (ctl.load),
      .step      (ctl.step),
      .load_den  (mag_b[i]),
      .load_quo  (mag_a[i]),
      .rem_in    (rem_in),
      .quo_in    (quo_in),
      .borrow_in (borrow_in),
      .ge        (ge),
      .rem_o     (rem_w[i]),
      .quo_o     (quo_w[i]),
      .borrow_o  (borrow_w[i])
    );
  end

  // Final sign and the two special cases.
  always_comb begin
    out_nxt.overflow    = ovf_r & ~dz_r;
    out_nxt.div_by_zero = dz_r;
    priority if (dz_r) begin
      out_nxt.quotient = '0;
    end else if (ovf_r) begin
      out_nxt.quotient = MAX_VAL;
    end else if (neg_r) begin
      out_nxt.quotient = DATA_WIDTH'(0) - quo_w;
    end else begin
      out_nxt.quotient = quo_w;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result is shown only in the cycle after the finishing step.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(ctl.finish))
    else $error("result strobe without a finishing step");

  // An accepted item makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // The two error flags never appear together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.overflow && out_data.div_by_zero))
    else $error("overflow and divide by zero both set");

  // A zero divisor always gives a zero quotient.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_by_zero) |-> (out_data.quotient == '0))
    else $error("nonzero quotient on divide by zero");

endmodule
